// ===== rtl/deletion_marker_range_search_top_macros.svh =====
// assertion macros for the deletion marker range search block
`ifndef DELETION_MARKER_RANGE_SEARCH_TOP_MACROS_SVH
`define DELETION_MARKER_RANGE_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMRS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define DMRS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/dmrs_pkg.sv =====
// shared types and constants of the deletion marker range search block
`timescale 1ns / 1ps
`default_nettype none
package dmrs_pkg;

	typedef logic [1:0] dmrs_cmd_t;
	typedef logic [1:0] dmrs_kind_t;

	localparam dmrs_cmd_t CMD_QUERY  = 2'd0;
	localparam dmrs_cmd_t CMD_SINGLE = 2'd1;
	localparam dmrs_cmd_t CMD_RUN    = 2'd2;
	localparam dmrs_cmd_t CMD_MIXED  = 2'd3;

	localparam dmrs_kind_t KIND_NONE    = 2'd0;
	localparam dmrs_kind_t KIND_RESTART = 2'd1;
	localparam dmrs_kind_t KIND_HIT     = 2'd2;
	localparam dmrs_kind_t KIND_OVERLAP = 2'd3;

	localparam logic [15:0] NO_OVERLAP      = 16'hFFFF;
	localparam logic [63:0] ALL_ONES_COMMIT = 64'hFFFF_FFFF_FFFF_FFFF;

	// classified record between front and back
	typedef struct packed {
		dmrs_kind_t  kind;
		logic        last;
		logic [15:0] off;
		logic [15:0] len;
		logic [63:0] commit;
	} dmrs_entry_t;

endpackage
`default_nettype wire

// ===== rtl/dmrs_front.sv =====
// front end: accepts beats, tracks the window and classifies each record
`timescale 1ns / 1ps
`default_nettype none
module dmrs_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire [1:0]            command,
	input  wire                  last_in_list,
	input  wire                  first_in_group,
	input  wire [15:0]           query_offset,
	input  wire [15:0]           query_span,
	input  wire [15:0]           marker_offset,
	input  wire [15:0]           run_length,
	input  wire [63:0]           commit_stamp,
	output dmrs_pkg::dmrs_entry_t entry
);
	import dmrs_pkg::*;

	logic [15:0] start_q;
	logic [16:0] win_end_q;
	logic        settled_q;

	logic [15:0] span_fix;
	logic [16:0] run_lo;
	logic [16:0] run_end;
	logic [16:0] run_hi;
	logic [16:0] run_len;
	logic        settled_eff;
	logic        settled_n;

	assign span_fix = (query_span == 16'd0) ? 16'd1 : query_span;
	assign run_lo   = (marker_offset > start_q) ? {1'b0, marker_offset} : {1'b0, start_q};
	assign run_end  = {1'b0, marker_offset} + {1'b0, run_length};
	assign run_hi   = (run_end < win_end_q) ? run_end : win_end_q;
	assign run_len  = run_hi - {1'b0, start_q};
	assign settled_eff = settled_q && !first_in_group;

	always_comb begin
		entry.kind   = KIND_NONE;
		entry.last   = last_in_list;
		entry.off    = marker_offset;
		entry.len    = 16'd1;
		entry.commit = commit_stamp;
		settled_n    = settled_q;
		case (command)
			CMD_QUERY: begin
				entry.kind = KIND_RESTART;
				entry.off  = query_offset;
				entry.len  = span_fix;
				settled_n  = 1'b0;
			end
			CMD_SINGLE: begin
				if (marker_offset == start_q) begin
					entry.kind = KIND_HIT;
				end else if (marker_offset > start_q && {1'b0, marker_offset} < win_end_q) begin
					entry.kind = KIND_OVERLAP;
				end
			end
			CMD_RUN: begin
				if (run_hi > run_lo) begin
					if (run_lo[15:0] == start_q) begin
						entry.kind = KIND_HIT;
						entry.len  = run_len[15:0];
					end else begin
						entry.kind = KIND_OVERLAP;
					end
				end
			end
			CMD_MIXED: begin
				settled_n = settled_eff;
				if (!settled_eff && marker_offset >= start_q) begin
					settled_n = 1'b1;
					if (marker_offset == start_q) begin
						entry.kind = KIND_HIT;
					end else if ({1'b0, marker_offset} < win_end_q) begin
						entry.kind = KIND_OVERLAP;
					end
				end
			end
			default: begin
				entry.kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 16'd0;
			win_end_q <= 17'd1;
			settled_q <= 1'b0;
		end else if (accept) begin
			settled_q <= settled_n;
			if (command == CMD_QUERY) begin
				start_q   <= query_offset;
				win_end_q <= {1'b0, query_offset} + {1'b0, span_fix};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dmrs_queue.sv =====
// short register queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module dmrs_queue #(
	parameter int DEPTH = 2
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  dmrs_pkg::dmrs_entry_t wr_entry,
	output logic                  full,
	input  wire                   pop,
	output dmrs_pkg::dmrs_entry_t rd_entry,
	output logic                  nonempty
);
	import dmrs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	dmrs_entry_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dmrs_back.sv =====
// back end: applies classified records and registers the result beat
`timescale 1ns / 1ps
`default_nettype none
module dmrs_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dmrs_pkg::dmrs_entry_t entry,
	input  wire                   entry_valid,
	output logic                  pop,
	output logic                  res_valid,
	input  wire                   res_ready,
	output logic                  found,
	output logic [63:0]           deletion_commit,
	output logic [15:0]           blocks_covered
);
	import dmrs_pkg::*;

	logic [15:0] start_q;
	logic [15:0] span_q;
	logic        hit_q;
	logic [63:0] commit_q;
	logic [15:0] hit_len_q;
	logic [15:0] lowest_q;

	logic [15:0] start_n;
	logic [15:0] span_n;
	logic        hit_n;
	logic [63:0] commit_n;
	logic [15:0] hit_len_n;
	logic [15:0] lowest_n;
	logic [15:0] gap;
	logic [15:0] clear_len;

	logic        res_valid_q;
	logic        found_q;
	logic [63:0] res_commit_q;
	logic [15:0] res_len_q;

	assign pop = entry_valid && (!res_valid_q || res_ready);

	always_comb begin
		start_n   = start_q;
		span_n    = span_q;
		hit_n     = hit_q;
		commit_n  = commit_q;
		hit_len_n = hit_len_q;
		lowest_n  = lowest_q;
		case (entry.kind)
			KIND_RESTART: begin
				start_n  = entry.off;
				span_n   = entry.len;
				hit_n    = 1'b0;
				lowest_n = NO_OVERLAP;
			end
			KIND_HIT: begin
				if (!hit_q) begin
					hit_n     = 1'b1;
					commit_n  = entry.commit;
					hit_len_n = entry.len;
				end
			end
			KIND_OVERLAP: begin
				if (!hit_q && entry.off < lowest_q) begin
					lowest_n = entry.off;
				end
			end
			default: begin
				hit_n = hit_q;
			end
		endcase
	end

	assign gap = lowest_n - start_n;

	always_comb begin
		clear_len = 16'd1;
		if (lowest_n == NO_OVERLAP) begin
			clear_len = span_n;
		end else if (lowest_n > start_n) begin
			clear_len = (gap < span_n) ? gap : span_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 16'd0;
			span_q      <= 16'd1;
			hit_q       <= 1'b0;
			hit_len_q   <= 16'd0;
			lowest_q    <= NO_OVERLAP;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				start_q   <= start_n;
				span_q    <= span_n;
				hit_q     <= hit_n;
				hit_len_q <= hit_len_n;
				lowest_q  <= lowest_n;
			end
			if (pop && entry.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			commit_q <= commit_n;
		end
		if (pop && entry.last) begin
			found_q      <= hit_n;
			res_commit_q <= hit_n ? commit_n : ALL_ONES_COMMIT;
			res_len_q    <= hit_n ? hit_len_n : clear_len;
		end
	end

	assign res_valid       = res_valid_q;
	assign found           = found_q;
	assign deletion_commit = res_commit_q;
	assign blocks_covered  = res_len_q;

endmodule
`default_nettype wire

// ===== rtl/deletion_marker_range_search_top.sv =====
// deletion marker range search: top level with front, queue and back
// a tlast beat is queued; the back end registers the result beat on popping it
// throughput: one input beat per cycle while the queue is not full
// the front classifies against its window copy, the queue lets both ends stall apart
// reset: arst_n clears the window to offset 0 span 1, no hit, queue empty
`timescale 1ns / 1ps
`default_nettype none
`include "deletion_marker_range_search_top_macros.svh"
module deletion_marker_range_search_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// query_offset, query_span, marker_offset, run_length, commit_stamp
	input  wire  [127:0] s_tdata,
	// command, first_in_group
	input  wire  [2:0]   s_tuser,
	input  wire          s_tlast,
	output logic         m_tvalid,
	input  wire          m_tready,
	// deletion_commit, blocks_covered
	output logic [79:0]  m_tdata,
	// found
	output logic [0:0]   m_tuser
);
	import dmrs_pkg::*;

	dmrs_entry_t front_entry;
	dmrs_entry_t back_entry;
	logic        q_full;
	logic        q_nonempty;
	logic        q_pop;
	logic        accept;
	logic        found;
	logic [63:0] deletion_commit;
	logic [15:0] blocks_covered;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	dmrs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.command        (s_tuser[1:0]),
		.last_in_list   (s_tlast),
		.first_in_group (s_tuser[2]),
		.query_offset   (s_tdata[15:0]),
		.query_span     (s_tdata[31:16]),
		.marker_offset  (s_tdata[47:32]),
		.run_length     (s_tdata[63:48]),
		.commit_stamp   (s_tdata[127:64]),
		.entry          (front_entry)
	);

	dmrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (back_entry),
		.nonempty (q_nonempty)
	);

	dmrs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.entry           (back_entry),
		.entry_valid     (q_nonempty),
		.pop             (q_pop),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.found           (found),
		.deletion_commit (deletion_commit),
		.blocks_covered  (blocks_covered)
	);

	assign m_tdata    = {blocks_covered, deletion_commit};
	assign m_tuser[0] = found;

	`DMRS_ASSERT_IMP(a_len_nonzero, clk, arst_n, m_tvalid, m_tdata[79:64] != 16'd0)
	`DMRS_ASSERT_IMP(a_miss_all_ones, clk, arst_n, m_tvalid && !m_tuser[0],
		m_tdata[63:0] == ALL_ONES_COMMIT)
	`DMRS_ASSERT_IMP(a_stall_has_data, clk, arst_n, !s_tready, q_nonempty)
	`DMRS_ASSERT_NXT(a_last_gives_beat, clk, arst_n, q_pop && back_entry.last, m_tvalid)

endmodule
`default_nettype wire
